// ===== design/sbpp_pkg.sv =====
// Shared types, constants and the key order table of the six-button pad poller.
// Used by sbpp_frame, sbpp_emit and six_button_pad_poller; depends on nothing.
`default_nettype none

package sbpp_pkg;

  // Field widths.
  localparam int PHASE_W   = 3;
  localparam int PIN_W     = 6;
  localparam int KEY_W     = 4;
  localparam int NUM_KEYS  = 12;
  localparam int DELAY_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Number of poll phases in a frame.
  localparam int PHASES_DEF = 8;

  // Phases whose samples take part in frame processing.
  localparam int PH_LINK  = 0;
  localparam int PH_ROW_A = 2;
  localparam int PH_ROW_B = 3;
  localparam int PH_ROW_C = 6;
  localparam int PH_TYPE  = 7;

  // Reset value of the connect delay register.
  localparam logic [DELAY_W-1:0] CONNECT_DELAY_RST = 8'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PINS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_DELAY = 2'd2;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_DPAD_UP    = 4'd0;
  localparam logic [KEY_W-1:0] KEY_DPAD_DOWN  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_DPAD_LEFT  = 4'd2;
  localparam logic [KEY_W-1:0] KEY_DPAD_RIGHT = 4'd3;
  localparam logic [KEY_W-1:0] KEY_A          = 4'd4;
  localparam logic [KEY_W-1:0] KEY_B          = 4'd5;
  localparam logic [KEY_W-1:0] KEY_C          = 4'd6;
  localparam logic [KEY_W-1:0] KEY_BTN_START  = 4'd7;
  localparam logic [KEY_W-1:0] KEY_X          = 4'd8;
  localparam logic [KEY_W-1:0] KEY_Y          = 4'd9;
  localparam logic [KEY_W-1:0] KEY_Z          = 4'd10;
  localparam logic [KEY_W-1:0] KEY_BTN_MODE   = 4'd11;

  // Link state of the pad.
  typedef enum logic [1:0] {
    LINK_DISC       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_INIT       = 2'd2,
    LINK_CONNECTED  = 2'd3
  } link_mode_t;

  // Kind of a result.
  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_CONNECTED    = 2'd1,
    EV_DISCONNECTED = 2'd2,
    EV_KEY          = 2'd3
  } event_t;

  // Configuration registers.
  typedef struct packed {
    logic                inv_pins;
    logic                invert_select;
    logic [DELAY_W-1:0]  connect_delay;
  } cfg_t;

  // Pad state kept between frames.
  typedef struct packed {
    link_mode_t          mode;
    logic [DELAY_W-1:0]  cnt;
    logic                six;
    logic                sensed;
    logic [NUM_KEYS-1:0] keys;
  } pad_state_t;

  // Everything needed to emit the results of one transfer.
  // The change mask is held in emission order, slot 0 first.
  typedef struct packed {
    logic                sel;
    event_t              link_ev;
    logic [NUM_KEYS-1:0] mask;
    logic [NUM_KEYS-1:0] keys;
  } plan_t;

  // Key reported in each emission slot.
  function automatic logic [KEY_W-1:0] slot_key(input logic [KEY_W-1:0] slot);
    logic [KEY_W-1:0] k;
    case (slot)
      4'd0:    k = KEY_A;
      4'd1:    k = KEY_BTN_START;
      4'd2:    k = KEY_DPAD_UP;
      4'd3:    k = KEY_DPAD_DOWN;
      4'd4:    k = KEY_DPAD_LEFT;
      4'd5:    k = KEY_DPAD_RIGHT;
      4'd6:    k = KEY_B;
      4'd7:    k = KEY_C;
      4'd8:    k = KEY_Z;
      4'd9:    k = KEY_Y;
      4'd10:   k = KEY_X;
      4'd11:   k = KEY_BTN_MODE;
      default: k = KEY_DPAD_UP;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/sbpp_frame.sv =====
// Frame processing of the pad poller: link sensing, connect wait, pad type and key changes.
// Purely combinational; depends on sbpp_pkg.
`default_nettype none

module sbpp_frame (
  input  wire  sbpp_pkg::cfg_t                  cfg,
  input  wire  sbpp_pkg::pad_state_t            cur,
  input  wire                                   process,
  input  wire  logic [sbpp_pkg::PHASE_W-1:0]    phase,
  input  wire  logic [sbpp_pkg::PIN_W-1:0]      s_link,
  input  wire  logic [sbpp_pkg::PIN_W-1:0]      s_row_a,
  input  wire  logic [sbpp_pkg::PIN_W-1:0]      s_row_b,
  input  wire  logic [sbpp_pkg::PIN_W-1:0]      s_row_c,
  input  wire  logic [sbpp_pkg::PIN_W-1:0]      s_type,
  output sbpp_pkg::pad_state_t                  nxt,
  output sbpp_pkg::plan_t                       plan
);

  logic [sbpp_pkg::PIN_W-1:0]    idle_level;
  logic                          sensed;
  logic [sbpp_pkg::DELAY_W-1:0]  cnt_inc;
  logic [sbpp_pkg::NUM_KEYS-1:0] pressed_now;
  logic [sbpp_pkg::NUM_KEYS-1:0] key_enable;
  logic [sbpp_pkg::NUM_KEYS-1:0] changed;
  logic                          sel;
  sbpp_pkg::event_t              link_ev;

  // Idle pin level depends on the input polarity.
  assign idle_level = cfg.inv_pins ? '1 : '0;
  assign sensed     = (s_link != idle_level);
  assign cnt_inc    = cur.cnt + 8'd1;

  // A key reads pressed when its pin is low.
  always_comb begin
    pressed_now                           = '0;
    pressed_now[sbpp_pkg::KEY_DPAD_UP]    = ~s_row_a[0];
    pressed_now[sbpp_pkg::KEY_DPAD_DOWN]  = ~s_row_a[1];
    pressed_now[sbpp_pkg::KEY_DPAD_LEFT]  = ~s_row_a[2];
    pressed_now[sbpp_pkg::KEY_DPAD_RIGHT] = ~s_row_a[3];
    pressed_now[sbpp_pkg::KEY_B]          = ~s_row_a[4];
    pressed_now[sbpp_pkg::KEY_C]          = ~s_row_a[5];
    pressed_now[sbpp_pkg::KEY_A]          = ~s_row_b[4];
    pressed_now[sbpp_pkg::KEY_BTN_START]  = ~s_row_b[5];
    pressed_now[sbpp_pkg::KEY_Z]          = ~s_row_c[0];
    pressed_now[sbpp_pkg::KEY_Y]          = ~s_row_c[1];
    pressed_now[sbpp_pkg::KEY_X]          = ~s_row_c[2];
    pressed_now[sbpp_pkg::KEY_BTN_MODE]   = ~s_row_c[3];
  end

  // The extra row only counts on a six-button pad.
  assign key_enable = cur.six ? '1 : 12'h0FF;

  // Next pad state at the last phase of a frame.
  always_comb begin
    nxt     = cur;
    changed = '0;
    link_ev = sbpp_pkg::EV_NONE;
    if (process) begin
      // Link change clears keys, pad type and the connect counter.
      if (sensed != cur.sensed) begin
        link_ev  = sensed ? sbpp_pkg::EV_CONNECTED : sbpp_pkg::EV_DISCONNECTED;
        nxt.mode = sensed ? sbpp_pkg::LINK_CONNECTING : sbpp_pkg::LINK_DISC;
        nxt.keys = '0;
        nxt.six  = 1'b0;
        nxt.cnt  = '0;
      end
      nxt.sensed = sensed;
      case (nxt.mode)
        sbpp_pkg::LINK_CONNECTING: begin
          if (cnt_inc >= cfg.connect_delay) begin
            nxt.cnt  = '0;
            nxt.mode = sbpp_pkg::LINK_INIT;
          end else begin
            nxt.cnt = cnt_inc;
          end
        end
        sbpp_pkg::LINK_INIT: begin
          nxt.six  = s_type[3] ^ cfg.inv_pins;
          nxt.mode = sbpp_pkg::LINK_CONNECTED;
        end
        sbpp_pkg::LINK_CONNECTED: begin
          changed  = (pressed_now ^ cur.keys) & key_enable;
          nxt.keys = cur.keys ^ changed;
        end
        default: begin
        end
      endcase
    end
  end

  // Select follows the phase parity once the pad is being read.
  always_comb begin
    if (cur.mode == sbpp_pkg::LINK_INIT || cur.mode == sbpp_pkg::LINK_CONNECTED) begin
      sel = phase[0];
    end else begin
      sel = 1'b1;
    end
  end

  // Reorder the change mask into emission order.
  always_comb begin
    plan.sel     = sel ^ cfg.invert_select;
    plan.link_ev = link_ev;
    plan.keys    = nxt.keys;
    for (int s = 0; s < sbpp_pkg::NUM_KEYS; s++) begin
      plan.mask[s] = changed[sbpp_pkg::slot_key(sbpp_pkg::KEY_W'(s))];
    end
  end

endmodule

`default_nettype wire

// ===== design/sbpp_emit.sv =====
// Result register of the pad poller: holds one transfer's plan and emits its results in order.
// Depends on sbpp_pkg.
`default_nettype none

module sbpp_emit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 load,
  input  wire  sbpp_pkg::plan_t               plan_in,
  output logic                                ready,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [7:0]                          out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  logic                            valid_r;
  sbpp_pkg::plan_t                 plan_r;
  logic [sbpp_pkg::NUM_KEYS-1:0]   low_bit;
  logic [sbpp_pkg::NUM_KEYS-1:0]   rest;
  logic [sbpp_pkg::KEY_W-1:0]      slot;
  logic [sbpp_pkg::KEY_W-1:0]      key;
  logic                            pressed;
  logic                            is_last;
  sbpp_pkg::event_t                ev;

  // Lowest pending slot and what remains after it.
  assign low_bit = plan_r.mask & (~plan_r.mask + 12'd1);
  assign rest    = plan_r.mask & (plan_r.mask - 12'd1);

  always_comb begin
    slot = '0;
    for (int i = 0; i < sbpp_pkg::NUM_KEYS; i++) begin
      slot = slot | (low_bit[i] ? sbpp_pkg::KEY_W'(i) : '0);
    end
  end

  // Fields of the result on offer.
  always_comb begin
    key     = '0;
    pressed = 1'b0;
    if (plan_r.link_ev != sbpp_pkg::EV_NONE) begin
      ev      = plan_r.link_ev;
      is_last = 1'b1;
    end else if (plan_r.mask == '0) begin
      ev      = sbpp_pkg::EV_NONE;
      is_last = 1'b1;
    end else begin
      ev      = sbpp_pkg::EV_KEY;
      key     = sbpp_pkg::slot_key(slot);
      pressed = plan_r.keys[key];
      is_last = (rest == '0);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, pressed, key, plan_r.sel};
  assign out_tuser  = ev;
  assign out_tlast  = is_last;

  // A new plan may enter as the last result of the current one leaves.
  assign ready = !valid_r || (out_tready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (valid_r && out_tready && is_last) begin
      valid_r <= 1'b0;
    end
  end

  // Plan payload; pending slots drop one per transfer.
  always_ff @(posedge clk) begin
    if (load) begin
      plan_r <= plan_in;
    end else if (valid_r && out_tready) begin
      plan_r.mask <= rest;
    end
  end

endmodule

`default_nettype wire

// ===== design/six_button_pad_poller.sv =====
// Six-button pad poller top level: configuration, pad state, phase sample store.
// Depends on sbpp_pkg, sbpp_frame and sbpp_emit.
//
//  channel  direction  ports                                   contents
//  in       slave      in_tvalid/tready/tdata                  phase, pins
//  out      master     out_tvalid/tready/tdata/tuser/tlast     select, event, key, pressed
//  cfg      slave      cfg_valid/ready/index/data              register writes
//
// An input transfer is processed in the cycle it is taken and its results sit in the
// result register from the next cycle. An item with several results holds off the next
// input until its last result is taken; otherwise one item per cycle while out_tready is high.
// The single result register is freed by the transfer of the last result of an item.
// Reset is synchronous and clears the pad state and configuration at once; the sample
// store is not cleared. Configuration writes are taken in every cycle.
`default_nettype none

module six_button_pad_poller (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: [2:0] phase, [8:3] pins
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  logic [15:0]                   in_tdata,
  // out_tdata: [0] select_level, [4:1] key, [5] key_pressed
  // out_tuser: [1:0] event_res
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [7:0]                          out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  logic [sbpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [7:0]                    cfg_data
);

  localparam int PHASES  = sbpp_pkg::PHASES_DEF;
  localparam int SAMP_AW = $clog2(PHASES);

  logic [sbpp_pkg::PHASE_W-1:0] in_phase;
  logic [sbpp_pkg::PIN_W-1:0]   in_pins;
  logic                         in_xfer;
  logic                         process;
  logic [sbpp_pkg::PIN_W-1:0]   s_type;

  sbpp_pkg::cfg_t               cfg_r;
  sbpp_pkg::pad_state_t         state_r;
  sbpp_pkg::pad_state_t         state_nxt;
  sbpp_pkg::plan_t              plan;

  logic [sbpp_pkg::PIN_W-1:0]   samples_r [PHASES];

  assign in_phase = in_tdata[2:0];
  assign in_pins  = in_tdata[8:3];
  assign in_xfer  = in_tvalid && in_tready;
  assign process  = (int'(in_phase) == PHASES - 1);

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_pins      <= 1'b0;
      cfg_r.invert_select <= 1'b0;
      cfg_r.connect_delay <= sbpp_pkg::CONNECT_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbpp_pkg::CFG_INV_PINS:      cfg_r.inv_pins      <= cfg_data[0];
        sbpp_pkg::CFG_INVERT_SELECT: cfg_r.invert_select <= cfg_data[0];
        sbpp_pkg::CFG_CONNECT_DELAY: cfg_r.connect_delay <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Phase sample store.
  always_ff @(posedge clk) begin
    if (in_xfer && int'(in_phase) < PHASES) begin
      samples_r[SAMP_AW'(in_phase)] <= in_pins;
    end
  end

  // The type phase sample is the incoming one when it is the current phase.
  assign s_type = (int'(in_phase) == sbpp_pkg::PH_TYPE) ? in_pins
                : samples_r[SAMP_AW'(sbpp_pkg::PH_TYPE)];

  sbpp_frame u_frame (
    .cfg     (cfg_r),
    .cur     (state_r),
    .process (process),
    .phase   (in_phase),
    .s_link  (samples_r[SAMP_AW'(sbpp_pkg::PH_LINK)]),
    .s_row_a (samples_r[SAMP_AW'(sbpp_pkg::PH_ROW_A)]),
    .s_row_b (samples_r[SAMP_AW'(sbpp_pkg::PH_ROW_B)]),
    .s_row_c (samples_r[SAMP_AW'(sbpp_pkg::PH_ROW_C)]),
    .s_type  (s_type),
    .nxt     (state_nxt),
    .plan    (plan)
  );

  // Pad state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode   <= sbpp_pkg::LINK_DISC;
      state_r.cnt    <= '0;
      state_r.six    <= 1'b0;
      state_r.sensed <= 1'b0;
      state_r.keys   <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  sbpp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .plan_in    (plan),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // Link events always stand alone.
  a_link_ev_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sbpp_pkg::EV_CONNECTED ||
                   out_tuser == sbpp_pkg::EV_DISCONNECTED) |-> out_tlast)
    else $error("link event not marked last");

  // Key events carry a real key code.
  a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sbpp_pkg::EV_KEY |-> out_tdata[4:1] <= sbpp_pkg::KEY_BTN_MODE)
    else $error("key event with bad key code");

  // An empty result register never blocks input.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // No key is held while the pad is disconnected.
  a_disc_keys: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == sbpp_pkg::LINK_DISC |-> state_r.keys == '0)
    else $error("keys held while disconnected");
`endif

endmodule

`default_nettype wire

// ===== dv/sbpp_checker.sv =====
// Scoreboard for the six-button pad poller: watches the input, result and register write
// channels, keeps its own copy of the pad state and checks every result transfer in order.
// Depends on sbpp_pkg for field widths, register indexes, key codes and enums.
`default_nettype none

module sbpp_checker
  import sbpp_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  input  wire                        in_tready,
  input  wire  logic [15:0]          in_tdata,
  input  wire                        out_tvalid,
  input  wire                        out_tready,
  input  wire  logic [7:0]           out_tdata,
  input  wire  logic [1:0]           out_tuser,
  input  wire                        out_tlast,
  input  wire                        cfg_valid,
  input  wire                        cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0] cfg_index,
  input  wire  logic [7:0]           cfg_data,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result of the poller, as it should appear on the result channel.
  typedef struct packed {
    logic             sel;
    event_t           ev;
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             last;
  } pad_result_t;

  pad_result_t         pad_results_q[$];
  pad_result_t         poll_results_q[$];

  // Shadow pad state and registers.
  logic [PIN_W-1:0]    samples [PHASES_DEF];
  logic [NUM_KEYS-1:0] keys;
  link_mode_t          mode;
  logic [DELAY_W-1:0]  frame_cnt;
  logic                six_button;
  logic                sensed;
  logic                inv_inputs;
  logic                inv_select;
  logic [DELAY_W-1:0]  delay_frames;
  logic                sel_level;

  // Collects one result of the current poll phase.
  function automatic void add_result(event_t ev, logic [KEY_W-1:0] key, logic pressed);
    pad_result_t r;
    r.sel     = sel_level;
    r.ev      = ev;
    r.key     = key;
    r.pressed = pressed;
    r.last    = 1'b0;
    poll_results_q.push_back(r);
  endfunction

  // A key reads pressed when its pin is low.
  function automatic void update_key(logic [KEY_W-1:0] key, int ph, int pin);
    logic pressed;
    pressed = ~samples[ph][pin];
    if (pressed != keys[key]) begin
      keys[key] = pressed;
      add_result(EV_KEY, key, pressed);
    end
  endfunction

  // A link change reports itself and drops all key and pad type knowledge.
  function automatic void change_link(event_t ev, link_mode_t next_mode);
    add_result(ev, '0, 1'b0);
    mode       = next_mode;
    keys       = '0;
    six_button = 1'b0;
    frame_cnt  = '0;
  endfunction

  // End-of-frame work: link sense, connect wait, pad type and key changes.
  function automatic void close_frame();
    logic             was_sensed;
    logic [PIN_W-1:0] idle_pins;
    was_sensed = sensed;
    idle_pins  = {PIN_W{inv_inputs}};
    sensed     = (samples[PH_LINK] != idle_pins);
    if (was_sensed != sensed) begin
      if (sensed) change_link(EV_CONNECTED, LINK_CONNECTING);
      else change_link(EV_DISCONNECTED, LINK_DISC);
    end
    case (mode)
      LINK_CONNECTING: begin
        frame_cnt = frame_cnt + 1'b1;
        if (frame_cnt >= delay_frames) begin
          frame_cnt = '0;
          mode      = LINK_INIT;
        end
      end
      LINK_INIT: begin
        // The mode pin of the last phase tells a six-button pad.
        six_button = samples[PH_TYPE][3] ^ inv_inputs;
        mode       = LINK_CONNECTED;
      end
      LINK_CONNECTED: begin
        update_key(KEY_A, PH_ROW_B, 4);
        update_key(KEY_BTN_START, PH_ROW_B, 5);
        update_key(KEY_DPAD_UP, PH_ROW_A, 0);
        update_key(KEY_DPAD_DOWN, PH_ROW_A, 1);
        update_key(KEY_DPAD_LEFT, PH_ROW_A, 2);
        update_key(KEY_DPAD_RIGHT, PH_ROW_A, 3);
        update_key(KEY_B, PH_ROW_A, 4);
        update_key(KEY_C, PH_ROW_A, 5);
        if (six_button) begin
          update_key(KEY_Z, PH_ROW_C, 0);
          update_key(KEY_Y, PH_ROW_C, 1);
          update_key(KEY_X, PH_ROW_C, 2);
          update_key(KEY_BTN_MODE, PH_ROW_C, 3);
        end
      end
      default: ;
    endcase
  endfunction

  // Works out every result of one accepted poll phase and queues them.
  function automatic void predict_poll(logic [PHASE_W-1:0] ph, logic [PIN_W-1:0] pins);
    pad_result_t r;
    if ((mode == LINK_INIT) || (mode == LINK_CONNECTED)) sel_level = ph[0];
    else sel_level = 1'b1;
    sel_level = sel_level ^ inv_select;
    poll_results_q.delete();
    samples[ph] = pins;
    if (int'(ph) == PHASES_DEF - 1) close_frame();
    if (poll_results_q.size() == 0) add_result(EV_NONE, '0, 1'b0);
    for (int i = 0; i < poll_results_q.size(); i++) begin
      r      = poll_results_q[i];
      r.last = (i == poll_results_q.size() - 1);
      pad_results_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
    end
  endfunction

  // Compares one result transfer with the oldest expectation.
  function automatic void check_result();
    pad_result_t want;
    pad_result_t got;
    got.sel     = out_tdata[0];
    got.key     = out_tdata[4:1];
    got.pressed = out_tdata[5];
    got.ev      = event_t'(out_tuser);
    got.last    = out_tlast;
    if (pad_results_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, expected none actual %p", $realtime, got);
      return;
    end
    want = pad_results_q.pop_front();
    check_field("select_level", want.sel, got.sel);
    check_field("event_res", int'(want.ev), int'(got.ev));
    check_field("key", want.key, got.key);
    check_field("key_pressed", want.pressed, got.pressed);
    check_field("last", want.last, got.last);
  endfunction

  // Register writes, then result checks, then prediction of newly accepted phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      keys         = '0;
      mode         = LINK_DISC;
      frame_cnt    = '0;
      six_button   = 1'b0;
      sensed       = 1'b0;
      inv_inputs   = 1'b0;
      inv_select   = 1'b0;
      delay_frames = CONNECT_DELAY_RST;
      errors       = 0;
      pad_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INV_PINS:      inv_inputs = cfg_data[0];
          CFG_INVERT_SELECT: inv_select = cfg_data[0];
          CFG_CONNECT_DELAY: delay_frames = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        predict_poll(in_tdata[PHASE_W-1:0], in_tdata[PHASE_W+PIN_W-1:PHASE_W]);
      end
    end
    pending = pad_results_q.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_six_button_pad_poller.sv =====
// Testbench top for the six-button pad poller: clock, reset, poll phase stimulus,
// register writes and random result back-pressure. Depends on sbpp_pkg, sbpp_checker
// and the six_button_pad_poller design.
`default_nettype none

module tb_six_button_pad_poller;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [15:0]          in_tdata   = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_INV_PINS;
  logic [7:0]           cfg_data   = '0;
  logic                 cfg_ready;
  int                   errors;
  int                   pending;
  int                   cycle_cnt  = 0;
  int                   polls_sent = 0;
  bit                   no_gaps    = 1'b0;
  bit                   pins_idle_high = 1'b0;
  logic [PIN_W-1:0]     pad_pins [PHASES_DEF];

  six_button_pad_poller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sbpp_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side stalls at random unless a gap-free stretch is running.
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 32);
  end

  // Hard stop in case the handshakes hang.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One poll phase transfer; starts and ends at a falling edge.
  task automatic send_poll(input logic [PHASE_W-1:0] ph, input logic [PIN_W-1:0] pins);
    while (!no_gaps && ($urandom_range(99) < 32)) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, pins, ph};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Holds the input back until every expected result has been transferred.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Next pin level for a phase: the link phase is mostly away from the idle level,
  // the others mostly keep or nudge what the pad showed last frame.
  function automatic logic [PIN_W-1:0] next_pins(input int ph);
    logic [PIN_W-1:0] p;
    logic [PIN_W-1:0] idle_pins;
    int               r;
    idle_pins = {PIN_W{pins_idle_high}};
    r = $urandom_range(99);
    if (ph == PH_LINK) begin
      p = PIN_W'($urandom);
      if (r < 8) p = idle_pins;
      else if (p == idle_pins) p = p ^ 6'h01;
    end else if (r < 45) begin
      p = pad_pins[ph];
    end else if (r < 75) begin
      p = pad_pins[ph] ^ (6'h01 << $urandom_range(PIN_W - 1));
    end else begin
      p = PIN_W'($urandom);
    end
    pad_pins[ph] = p;
    return p;
  endfunction

  // Mostly whole frames in order; the rest are cut-short frames and stray phases.
  task automatic run_random(input int count);
    int               start;
    int               r;
    logic [PHASE_W-1:0] ph;
    start = polls_sent;
    while (polls_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 80) begin
        for (int i = 0; i < PHASES_DEF; i++) send_poll(PHASE_W'(i), next_pins(i));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) begin
          ph = PHASE_W'($urandom_range(PHASES_DEF - 2));
          send_poll(ph, next_pins(int'(ph)));
        end
        send_poll(PHASE_W'(PH_TYPE), next_pins(PH_TYPE));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_poll(PHASE_W'($urandom_range(PHASES_DEF - 1)), PIN_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: connect, detect a six-button pad, press and release keys, drop and return.
    write_reg(CFG_CONNECT_DELAY, 8'd1);
    for (int i = 0; i < PHASES_DEF; i++) send_poll(PHASE_W'(i), 6'h3F);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    send_poll(PHASE_W'(PH_ROW_A), 6'h00);
    send_poll(PHASE_W'(PH_ROW_B), 6'h00);
    send_poll(PHASE_W'(PH_ROW_C), 6'h00);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    send_poll(PHASE_W'(PH_ROW_A), 6'h15);
    send_poll(PHASE_W'(PH_ROW_B), 6'h2A);
    send_poll(PHASE_W'(PH_ROW_C), 6'h2A);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    send_poll(PHASE_W'(PH_LINK), 6'h00);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    send_poll(PHASE_W'(PH_LINK), 6'h01);
    send_poll(PHASE_W'(PH_TYPE), 6'h3F);
    for (int i = 0; i < PHASES_DEF; i++) pad_pins[i] = 6'h3F;

    // Inverted select line, shortest real connect wait.
    drain_results();
    write_reg(CFG_INVERT_SELECT, 8'd1);
    run_random(110);

    // Pins idle high and a zero connect wait.
    drain_results();
    write_reg(CFG_INV_PINS, 8'd1);
    pins_idle_high = 1'b1;
    write_reg(CFG_CONNECT_DELAY, 8'd0);
    write_reg(CFG_INVERT_SELECT, 8'd0);
    run_random(110);

    // Longest connect wait, run without any gaps on either side.
    drain_results();
    write_reg(CFG_CONNECT_DELAY, 8'hFF);
    no_gaps = 1'b1;
    run_random(40);
    no_gaps = 1'b0;

    // Back to idle-low pins with a short wait and inverted select.
    drain_results();
    write_reg(CFG_INV_PINS, 8'd0);
    pins_idle_high = 1'b0;
    write_reg(CFG_CONNECT_DELAY, 8'd2);
    write_reg(CFG_INVERT_SELECT, 8'd1);
    run_random(100);

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
